FILE: rtl/dld_pkg.sv
// Shared widths, limits and a helper function of the decimal long divider.
`timescale 1ns / 1ps
`default_nettype none

package dld_pkg;

    localparam int MAX_DIGITS  = 9;
    localparam int DIVIDEND_W  = 30;
    localparam int DIVISOR_W   = 30;
    localparam int PARTIAL_W   = 34;
    localparam int POS_W       = 4;
    localparam int QDIGIT_W    = 4;
    localparam int BCD_W       = 4 * MAX_DIGITS;
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W   = $clog2(DIVIDEND_W + 1);

    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam longint unsigned DIV_LIMIT = pow10(MAX_DIGITS) - 1;

endpackage

`default_nettype wire

FILE: rtl/decimal_long_divider.sv
// Decimal long divider: digit-serial schoolbook division with per-step results.
// Steps: capture and check, serial BCD conversion, dropping of leading zero digits, then per
// digit a bring-down and repeated subtraction, with a step item for each nonzero quotient
// digit, then the final item; zero divisor or dividend below the divisor: final item only.
// Throughput: one item at a time; the next is taken once the final result is registered.
// Reset (aresetn low, synchronous) clears the control state and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module decimal_long_divider (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [dld_pkg::DIVIDEND_W-1:0]      s_dividend,
    input  wire logic [dld_pkg::DIVISOR_W-1:0]       s_divisor,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [dld_pkg::PARTIAL_W-1:0]       m_partial_dividend,
    output logic      [dld_pkg::PARTIAL_W-1:0]       m_product,
    output logic      [dld_pkg::POS_W-1:0]           m_digit_position,
    output logic      [dld_pkg::DIVIDEND_W-1:0]      m_quotient,
    output logic      [dld_pkg::DIVIDEND_W-1:0]      m_remainder,
    output logic                                     m_div_by_zero,
    output logic                                     m_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CONV,
        ST_NORM,
        ST_BRING,
        ST_SUB,
        ST_EMIT,
        ST_FINAL
    } state_t;

    state_t                              state_reg;
    logic [dld_pkg::DIVIDEND_W-1:0]      a_reg;
    logic [dld_pkg::DIVISOR_W-1:0]       b_reg;
    logic [dld_pkg::BCD_W-1:0]           digits_reg;
    logic [dld_pkg::DIGIT_CNT_W-1:0]     rem_cnt_reg;
    logic [dld_pkg::POS_W-1:0]           pos_reg;
    logic [dld_pkg::PARTIAL_W-1:0]       partial_reg;
    logic [dld_pkg::PARTIAL_W-1:0]       pd_reg;
    logic [dld_pkg::QDIGIT_W-1:0]        qd_reg;
    logic [dld_pkg::DIVIDEND_W-1:0]      q_reg;
    logic                                dz_reg;

    logic                                m_valid_reg;
    logic [dld_pkg::PARTIAL_W-1:0]       m_partial_dividend_reg;
    logic [dld_pkg::PARTIAL_W-1:0]       m_product_reg;
    logic [dld_pkg::POS_W-1:0]           m_digit_position_reg;
    logic [dld_pkg::DIVIDEND_W-1:0]      m_quotient_reg;
    logic [dld_pkg::DIVIDEND_W-1:0]      m_remainder_reg;
    logic                                m_div_by_zero_reg;
    logic                                m_last_reg;

    logic [dld_pkg::DIVIDEND_W-1:0]      a_sat;
    logic [3:0]                          top_digit;
    logic [dld_pkg::PARTIAL_W-1:0]       partial_next;
    logic [dld_pkg::PARTIAL_W:0]         diff;
    logic                                partial_ge;
    logic [dld_pkg::DIVIDEND_W-1:0]      q_next;
    logic                                out_free;
    logic                                out_load;
    logic                                conv_start;
    logic                                conv_done;
    logic [dld_pkg::BCD_W-1:0]           conv_bcd;

    assign a_sat = (64'(s_dividend) > dld_pkg::DIV_LIMIT)
                 ? dld_pkg::DIV_LIMIT[dld_pkg::DIVIDEND_W-1:0] : s_dividend;

    assign top_digit    = digits_reg[dld_pkg::BCD_W-1 -: 4];
    assign partial_next = (partial_reg << 3) + (partial_reg << 1)
                        + dld_pkg::PARTIAL_W'(top_digit);
    assign diff         = {1'b0, partial_reg}
                        - (dld_pkg::PARTIAL_W+1)'(b_reg);
    assign partial_ge   = !diff[dld_pkg::PARTIAL_W];
    assign q_next       = (q_reg << 3) + (q_reg << 1)
                        + dld_pkg::DIVIDEND_W'(qd_reg);
    assign out_free     = !m_valid_reg || m_ready;
    assign out_load     = ((state_reg == ST_EMIT) || (state_reg == ST_FINAL)) && out_free;
    assign conv_start   = (state_reg == ST_START) && (b_reg != '0)
                        && (a_reg >= b_reg);

    dld_bin2bcd u_bin2bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .bin     (a_reg),
        .done    (conv_done),
        .bcd     (conv_bcd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        a_reg     <= a_sat;
                        b_reg     <= s_divisor;
                        state_reg <= ST_START;
                    end
                end
                ST_START: begin
                    pos_reg     <= '0;
                    q_reg       <= '0;
                    dz_reg      <= (b_reg == '0);
                    if ((b_reg == '0) || (a_reg < b_reg)) begin
                        partial_reg <= dld_pkg::PARTIAL_W'(a_reg);
                        state_reg   <= ST_FINAL;
                    end else begin
                        partial_reg <= '0;
                        state_reg   <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        digits_reg  <= conv_bcd;
                        rem_cnt_reg <= dld_pkg::DIGIT_CNT_W'(dld_pkg::MAX_DIGITS);
                        state_reg   <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if ((top_digit == 4'd0)
                        && (rem_cnt_reg > dld_pkg::DIGIT_CNT_W'(1))) begin
                        digits_reg  <= digits_reg << 4;
                        rem_cnt_reg <= rem_cnt_reg - dld_pkg::DIGIT_CNT_W'(1);
                    end else begin
                        state_reg <= ST_BRING;
                    end
                end
                ST_BRING: begin
                    pd_reg      <= partial_next;
                    partial_reg <= partial_next;
                    digits_reg  <= digits_reg << 4;
                    qd_reg      <= '0;
                    state_reg   <= ST_SUB;
                end
                ST_SUB: begin
                    if (partial_ge) begin
                        partial_reg <= diff[dld_pkg::PARTIAL_W-1:0];
                        qd_reg      <= qd_reg + dld_pkg::QDIGIT_W'(1);
                    end else begin
                        q_reg <= q_next;
                        if (qd_reg != '0) begin
                            state_reg <= ST_EMIT;
                        end else if (rem_cnt_reg == dld_pkg::DIGIT_CNT_W'(1)) begin
                            state_reg <= ST_FINAL;
                        end else begin
                            rem_cnt_reg <= rem_cnt_reg - dld_pkg::DIGIT_CNT_W'(1);
                            pos_reg     <= pos_reg + dld_pkg::POS_W'(1);
                            state_reg   <= ST_BRING;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_partial_dividend_reg <= pd_reg;
                        m_product_reg          <= pd_reg - partial_reg;
                        m_digit_position_reg   <= pos_reg;
                        m_quotient_reg         <= '0;
                        m_remainder_reg        <= '0;
                        m_div_by_zero_reg      <= 1'b0;
                        m_last_reg             <= 1'b0;
                        if (rem_cnt_reg == dld_pkg::DIGIT_CNT_W'(1)) begin
                            state_reg <= ST_FINAL;
                        end else begin
                            rem_cnt_reg <= rem_cnt_reg - dld_pkg::DIGIT_CNT_W'(1);
                            pos_reg     <= pos_reg + dld_pkg::POS_W'(1);
                            state_reg   <= ST_BRING;
                        end
                    end
                end
                ST_FINAL: begin
                    if (out_free) begin
                        m_partial_dividend_reg <= '0;
                        m_product_reg          <= '0;
                        m_digit_position_reg   <= '0;
                        m_quotient_reg         <= q_reg;
                        m_remainder_reg        <= partial_reg[dld_pkg::DIVIDEND_W-1:0];
                        m_div_by_zero_reg      <= dz_reg;
                        m_last_reg             <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_partial_dividend = m_partial_dividend_reg;
    assign m_product          = m_product_reg;
    assign m_digit_position   = m_digit_position_reg;
    assign m_quotient         = m_quotient_reg;
    assign m_remainder        = m_remainder_reg;
    assign m_div_by_zero      = m_div_by_zero_reg;
    assign m_last             = m_last_reg;

`ifndef ASSERT_OFF
    a_final_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> (m_partial_dividend == '0) && (m_product == '0))
        else $error("final item carries step fields");

    a_step_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> (m_product != '0) && (m_product <= m_partial_dividend)
            && (m_digit_position < dld_pkg::POS_W'(dld_pkg::MAX_DIGITS))
            && !m_div_by_zero)
        else $error("step item out of range");

    a_conv_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_done |-> (state_reg == ST_CONV))
        else $error("conversion finished outside its state");

    a_sub_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUB) |-> (qd_reg <= dld_pkg::QDIGIT_W'(9)))
        else $error("quotient digit above nine");
`endif

endmodule

`default_nettype wire

FILE: rtl/dld_bin2bcd.sv
// Bit-serial binary to packed BCD converter (shift and add three).
`timescale 1ns / 1ps
`default_nettype none

module dld_bin2bcd (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [dld_pkg::DIVIDEND_W-1:0]     bin,
    output logic                                    done,
    output logic      [dld_pkg::BCD_W-1:0]          bcd
);

    logic [dld_pkg::DIVIDEND_W-1:0] bin_reg;
    logic [dld_pkg::DIVIDEND_W-1:0] bin_next;
    logic [dld_pkg::BCD_W-1:0]      bcd_reg;
    logic [dld_pkg::BCD_W-1:0]      bcd_next;
    logic [dld_pkg::BCD_W-1:0]      adj;
    logic [dld_pkg::BIT_CNT_W-1:0]  cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    always_comb begin
        logic [3:0] nib;
        nib = '0;
        for (int i = 0; i < dld_pkg::MAX_DIGITS; i++) begin
            nib = bcd_reg[4*i +: 4];
            adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
        bcd_next = {adj[dld_pkg::BCD_W-2:0], bin_reg[dld_pkg::DIVIDEND_W-1]};
        bin_next = {bin_reg[dld_pkg::DIVIDEND_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= dld_pkg::BIT_CNT_W'(dld_pkg::DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - dld_pkg::BIT_CNT_W'(1);
                if (cnt_reg == dld_pkg::BIT_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            bin_reg <= bin;
            bcd_reg <= '0;
        end else if (busy_reg) begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the decimal long divider: predicted steps against the results.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 180;
    localparam int MAX_WAIT = 14;

    typedef logic [dld_pkg::DIVIDEND_W-1:0] dividend_t;
    typedef logic [dld_pkg::DIVISOR_W-1:0] divisor_t;

    typedef struct {
        logic [dld_pkg::PARTIAL_W-1:0]  partial_dividend;
        logic [dld_pkg::PARTIAL_W-1:0]  product;
        logic [dld_pkg::POS_W-1:0]      digit_position;
        logic [dld_pkg::DIVIDEND_W-1:0] quotient;
        logic [dld_pkg::DIVIDEND_W-1:0] remainder;
        logic                           div_by_zero;
        logic                           last;
    } div_result_t;

    class division_tracker;
        div_result_t expected_results[$];
        int errors = 0;

        task report(string what, longint unsigned got, longint unsigned want);
            $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
            errors++;
        endtask

        function int pending();
            return expected_results.size();
        endfunction

        function void push_final(longint unsigned quo, longint unsigned rem, bit dz);
            div_result_t r;
            r.partial_dividend = '0;
            r.product = '0;
            r.digit_position = '0;
            r.quotient = dld_pkg::DIVIDEND_W'(quo);
            r.remainder = dld_pkg::DIVIDEND_W'(rem);
            r.div_by_zero = dz;
            r.last = 1'b1;
            expected_results.push_back(r);
        endfunction

        // Work out the long division and queue an item per nonzero quotient digit and the final item.
        function void note_item(dividend_t dividend, divisor_t divisor);
            longint unsigned num;
            longint unsigned den;
            longint unsigned rest;
            longint unsigned partial;
            longint unsigned quo;
            longint unsigned qd;
            int n;
            int digit[20];
            div_result_t r;
            num = dividend;
            den = divisor;
            if (num > dld_pkg::DIV_LIMIT) begin
                num = dld_pkg::DIV_LIMIT;
            end
            if (den == 0) begin
                push_final(0, num, 1'b1);
                return;
            end
            if (num < den) begin
                push_final(0, num, 1'b0);
                return;
            end
            n = 0;
            rest = num;
            do begin
                digit[n] = int'(rest % 10);
                rest = rest / 10;
                n++;
            end while (rest != 0);
            partial = 0;
            quo = 0;
            for (int i = 0; i < n; i++) begin
                partial = partial * 10 + longint'(digit[n - 1 - i]);
                if (partial >= den) begin
                    qd = partial / den;
                    r.partial_dividend = dld_pkg::PARTIAL_W'(partial);
                    r.product = dld_pkg::PARTIAL_W'(qd * den);
                    r.digit_position = dld_pkg::POS_W'(i);
                    r.quotient = '0;
                    r.remainder = '0;
                    r.div_by_zero = 1'b0;
                    r.last = 1'b0;
                    expected_results.push_back(r);
                    partial = partial - qd * den;
                    quo = quo * 10 + qd;
                end else begin
                    quo = quo * 10;
                end
            end
            push_final(quo, partial, 1'b0);
        endfunction

        task check_result(div_result_t got);
            div_result_t want;
            if (expected_results.size() == 0) begin
                report("unexpected result, partial_dividend", got.partial_dividend, 0);
                return;
            end
            want = expected_results.pop_front();
            if (got.partial_dividend !== want.partial_dividend)
                report("partial_dividend", got.partial_dividend, want.partial_dividend);
            if (got.product !== want.product)
                report("product", got.product, want.product);
            if (got.digit_position !== want.digit_position)
                report("digit_position", got.digit_position, want.digit_position);
            if (got.quotient !== want.quotient)
                report("quotient", got.quotient, want.quotient);
            if (got.remainder !== want.remainder)
                report("remainder", got.remainder, want.remainder);
            if (got.div_by_zero !== want.div_by_zero)
                report("div_by_zero", got.div_by_zero, want.div_by_zero);
            if (got.last !== want.last)
                report("last", got.last, want.last);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    dividend_t s_dividend = '0;
    divisor_t s_divisor = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [dld_pkg::PARTIAL_W-1:0] m_partial_dividend;
    logic [dld_pkg::PARTIAL_W-1:0] m_product;
    logic [dld_pkg::POS_W-1:0] m_digit_position;
    logic [dld_pkg::DIVIDEND_W-1:0] m_quotient;
    logic [dld_pkg::DIVIDEND_W-1:0] m_remainder;
    logic m_div_by_zero;
    logic m_last;

    division_tracker tracker = new;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    int cycle_count = 0;

    longint unsigned decade[10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                    10000000, 100000000, 1000000000};

    dividend_t dir_dividend[21] = '{
        0, 0, 5, 30'h3FFFFFFF, 999999999, 30'h3FFFFFFF, 1000000000, 30'h3FFFFFFF,
        999999999, 7, 6, 1, 100000000, 100000001, 123456789, 987654321, 10,
        500000000, 999999999, 808080808, 12};
    divisor_t dir_divisor[21] = '{
        0, 7, 0, 0, 1, 1, 3, 30'h3FFFFFFF,
        999999999, 7, 7, 1, 1, 7, 12345, 9, 3,
        999999998, 9, 8, 30'h3FFFFFFF};

    always #5 aclk = ~aclk;

    decimal_long_divider dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_dividend         (s_dividend),
        .s_divisor          (s_divisor),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_partial_dividend (m_partial_dividend),
        .m_product          (m_product),
        .m_digit_position   (m_digit_position),
        .m_quotient         (m_quotient),
        .m_remainder        (m_remainder),
        .m_div_by_zero      (m_div_by_zero),
        .m_last             (m_last)
    );

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_division(dividend_t dividend, divisor_t divisor);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_dividend <= dividend;
        s_divisor <= divisor;
        do @(posedge aclk); while (!s_ready);
        tracker.note_item(dividend, divisor);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (tracker.pending() != 0);
    endtask

    task automatic pick_operands(output dividend_t dividend, output divisor_t divisor);
        int kind;
        int nd;
        int nv;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                dividend = dividend_t'($urandom);
                divisor = '0;
            end
            1: begin
                dividend = dividend_t'($urandom);
                divisor = divisor_t'($urandom);
            end
            2: begin
                divisor = divisor_t'($urandom_range(1, 999999999));
                dividend = dividend_t'($urandom_range(0, int'(divisor) - 1));
            end
            default: begin
                nd = $urandom_range(1, 9);
                nv = $urandom_range(1, nd);
                dividend = dividend_t'($urandom_range(0, int'(decade[nd] - 1)));
                divisor = divisor_t'($urandom_range(1, int'(decade[nv] - 1)));
            end
        endcase
    endtask

    initial begin : receiver
        int stall;
        div_result_t got;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.partial_dividend = m_partial_dividend;
            got.product = m_product;
            got.digit_position = m_digit_position;
            got.quotient = m_quotient;
            got.remainder = m_remainder;
            got.div_by_zero = m_div_by_zero;
            got.last = m_last;
            tracker.check_result(got);
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("decimal_long_divider test failed");
        $finish;
    end

    initial begin : stimulus
        dividend_t dd;
        divisor_t dv;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (dir_dividend[i]) begin
            offer_division(dir_dividend[i], dir_divisor[i]);
        end
        drain_results();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 40) begin
                hold_req = 1'b1;
            end
            if (i == 90) begin
                drain_results();
            end
            no_idle = (i >= 110 && i < 140);
            pick_operands(dd, dv);
            offer_division(dd, dv);
        end
        no_idle = 1'b0;
        drain_results();
        repeat (200) @(negedge aclk);
        if (tracker.pending() != 0) begin
            tracker.report("results never arrived", tracker.pending(), 0);
        end
        if (tracker.errors == 0) begin
            $display("decimal_long_divider test passed");
        end else begin
            $display("decimal_long_divider test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/dld_pkg.sv
rtl/dld_bin2bcd.sv
rtl/decimal_long_divider.sv
tb/tb_top.sv
